@@ rtl/signed_int_to_decimal_ascii_unit_macros.svh @@
// assertion macros for the decimal text unit
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// clocked check, off while reset is held
`define SIDTOA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// clocked check that also holds during reset
`define SIDTOA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ rtl/sidtoa_pkg.sv @@
`timescale 1ns / 1ps
package sidtoa_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int DIGITS_MAX  = 10;
    localparam int NDIG_W      = $clog2(DIGITS_MAX + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    // reciprocal of ten for an exact unsigned 32-bit quotient
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ rtl/signed_int_to_decimal_ascii_unit.sv @@
// an accepted value passes the front register and the queue before the back end takes it
// the back end takes a new value only from idle, after the last character of the previous one
// the back end divides by ten once per cycle, then sends sign and digits, one per cycle unless m_tready stalls
// reset: synchronous active-low aresetn clears valid flags, queue pointers and the fsm
// payload and digit registers are not reset
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_unit_macros.svh"
module signed_int_to_decimal_ascii_unit
    import sidtoa_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CHAR_W-1:0]  m_tdata,   // [7:0] character
    output logic               m_tlast    // last character of the value
);

    // front stage to queue
    logic          push_valid;
    logic          push_ready;
    queue_entry_t  push_entry;

    // queue to back end
    logic          pop_valid;
    logic          pop_ready;
    queue_entry_t  pop_entry;
    queue_status_t q_status;

    // front: take the item, split off sign and form the magnitude
    sidtoa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // short queue so the front keeps taking items while the back end works
    sidtoa_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    // back: digit extraction, then sign and digits most significant first
    sidtoa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // a negative value always has a nonzero magnitude
    `SIDTOA_ASSERT(a_neg_mag, push_valid && push_entry.neg |-> push_entry.mag != '0, "negative item with zero magnitude")

    // a minus sign is never the final character
    `SIDTOA_ASSERT(a_minus_not_last, m_tvalid && m_tdata == CHAR_MINUS |-> !m_tlast, "minus sign marked last")

    // output is a minus sign or a decimal digit
    `SIDTOA_ASSERT(a_char_range, m_tvalid |-> (m_tdata == CHAR_MINUS || (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_ZERO + 8'd9)), "character out of range")

    // queue can never be full and empty together
    `SIDTOA_ASSERT(a_queue_status, !(q_status.full && q_status.empty), "queue full and empty")

endmodule

@@ rtl/sidtoa_front.sv @@
`timescale 1ns / 1ps
module sidtoa_front
    import sidtoa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,
    output logic               push_valid,
    input  logic               push_ready,
    output queue_entry_t       push_entry
);

    logic         valid_reg;
    logic         valid_next;
    queue_entry_t entry_reg;
    queue_entry_t entry_next;

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    // sign split and unsigned magnitude, exact for the most negative value
    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (push_ready) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next     = 1'b1;
            entry_next.neg = s_tdata[VALUE_W-1];
            entry_next.mag = s_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_tdata) : s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

endmodule

@@ rtl/sidtoa_queue.sv @@
`timescale 1ns / 1ps
module sidtoa_queue
    import sidtoa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  queue_entry_t  push_entry,
    output logic          pop_valid,
    input  logic          pop_ready,
    output queue_entry_t  pop_entry,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    queue_entry_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign pop_entry    = slots_reg[rd_ptr_reg];
    assign do_push      = push_valid && push_ready;
    assign do_pop       = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/sidtoa_back.sv @@
`timescale 1ns / 1ps
module sidtoa_back
    import sidtoa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  queue_entry_t      pop_entry,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,
    output logic              m_tlast
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_SIGN  = 4'b0100,
        S_DIGIT = 4'b1000
    } back_state_t;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [VALUE_W-1:0]  mag_reg;
    logic [VALUE_W-1:0]  mag_next;
    logic                neg_reg;
    logic                neg_next;
    logic [NDIG_W-1:0]   nd_reg;
    logic [NDIG_W-1:0]   nd_next;
    logic [DIGIT_W-1:0]  digs_reg [DIGITS_MAX];
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg;
    logic [CHAR_W-1:0]   out_char_next;
    logic                out_last_reg;
    logic                out_last_next;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   quot_x10;
    logic [VALUE_W-1:0]   rem_full;
    logic [DIGIT_W-1:0]   rem;
    logic [NDIG_W-1:0]    nd_inc;
    logic [NDIG_W-1:0]    rd_idx;
    logic                 out_free;

    // divide by ten through the reciprocal, remainder by back-multiply
    assign prod     = mag_reg * RECIP_TEN;
    assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = mag_reg - quot_x10;
    assign rem      = rem_full[DIGIT_W-1:0];
    assign nd_inc   = nd_reg + 1'b1;
    assign rd_idx   = nd_reg - 1'b1;
    assign out_free = !out_valid_reg || m_tready;

    assign pop_ready = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_char_reg;
    assign m_tlast   = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        nd_next        = nd_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (pop_valid) begin
                    mag_next   = pop_entry.mag;
                    neg_next   = pop_entry.neg;
                    nd_next    = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                mag_next = quot;
                nd_next  = nd_inc;
                if (quot == '0 || nd_inc == NDIG_W'(DIGITS_MAX)) begin
                    state_next = neg_reg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + CHAR_W'(digs_reg[rd_idx[$clog2(DIGITS_MAX)-1:0]]);
                    out_last_next  = (nd_reg == NDIG_W'(1));
                    nd_next        = rd_idx;
                    if (nd_reg == NDIG_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        nd_reg       <= nd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (state_reg == S_DIV) begin
            digs_reg[nd_reg[$clog2(DIGITS_MAX)-1:0]] <= rem;
        end
    end

endmodule
